[rtl/snrm_pkg.sv]
// Shared types, constants and codes for the spectral noise running mean block.
package snrm_pkg;

	localparam int DEF_MAX_BINS   = 2048;
	localparam int DEF_VALUE_BITS = 32;

	localparam int BIN_BITS   = 11;
	localparam int OUT_BITS   = 32;
	localparam int COUNT_BITS = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [BIN_BITS-1:0]   BIN_TOP    = 11'h7FF;
	localparam logic [BIN_BITS-1:0]   LAST_RESET = 11'd1024;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic div_start;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic copy_mode;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

[rtl/snrm_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned dividend by 16-bit divisor.
module snrm_div import snrm_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic [VALUE_BITS-1:0] quotient,
	output logic                  done
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [COUNT_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;

	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[rtl/snrm_ctrl.sv]
// Controller state machine: sequences capture, divide (skipped in the first frame) and commit of one bin.
module snrm_ctrl import snrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_stall
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CALC;
				end
			end
			ST_CALC: begin
				if (sts.copy_mode) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/snrm_dp.sv]
// Datapath: bin store, frame counters, mean update and result register.
module snrm_dp import snrm_pkg::*; #(
	parameter int MAX_BINS   = DEF_MAX_BINS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [BIN_BITS-1:0]   cfg_data,
	input  logic [VALUE_BITS-1:0] spectrum_value,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [BIN_BITS-1:0]   bin_index,
	output logic [OUT_BITS-1:0]   noise_value,
	output logic                  frame_last,
	output logic                  profile_available
);

	localparam int AW = $clog2(MAX_BINS);
	localparam logic [BIN_BITS-1:0] LAST_CAP =
		(MAX_BINS - 1 > int'(BIN_TOP)) ? BIN_TOP : BIN_BITS'(MAX_BINS - 1);

	logic [VALUE_BITS-1:0] noise_store_q [MAX_BINS];

	logic [BIN_BITS-1:0]   last_bin_q;
	logic [BIN_BITS-1:0]   bin_pos_q;
	logic [COUNT_BITS-1:0] frame_count_q;
	logic                  avail_q;

	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] rd_q;
	logic [BIN_BITS-1:0]   pos_q;
	logic                  sign_q;

	logic                  out_valid_q;
	logic [BIN_BITS-1:0]   out_bin_q;
	logic [OUT_BITS-1:0]   out_value_q;
	logic                  out_last_q;
	logic                  out_avail_q;

	logic [BIN_BITS-1:0]   pos_eff;
	logic [BIN_BITS-1:0]   last_eff;
	logic [VALUE_BITS:0]   diff;
	logic [VALUE_BITS:0]   diff_neg;
	logic [VALUE_BITS-1:0] mag;
	logic [COUNT_BITS-1:0] divisor;
	logic [VALUE_BITS-1:0] quotient;
	logic                  div_done;
	logic [VALUE_BITS-1:0] mean;
	logic                  closes;
	logic                  out_free;

	always_comb begin
		pos_eff  = (bin_pos_q > LAST_CAP) ? LAST_CAP : bin_pos_q;
		last_eff = (last_bin_q > LAST_CAP) ? LAST_CAP : last_bin_q;
		diff     = {1'b0, v_q} - {1'b0, rd_q};
		diff_neg = ~diff + 1'b1;
		mag      = diff[VALUE_BITS] ? diff_neg[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
		divisor  = (frame_count_q == COUNT_MAX) ? COUNT_MAX : frame_count_q + 1'b1;
		if (frame_count_q == '0) begin
			mean = v_q;
		end else if (sign_q) begin
			mean = rd_q - quotient;
		end else begin
			mean = rd_q + quotient;
		end
		closes   = (pos_q >= last_eff);
		out_free = !out_valid_q || !out_stall;
	end

	snrm_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(mag),
		.divisor (divisor),
		.quotient(quotient),
		.done    (div_done)
	);

	// store: read at capture, written at commit
	always_ff @(posedge clk) begin
		if (cmd.capture) rd_q <= noise_store_q[AW'(pos_eff)];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) noise_store_q[AW'(pos_q)] <= mean;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			v_q   <= spectrum_value;
			pos_q <= pos_eff;
		end
		if (cmd.div_start) sign_q <= diff[VALUE_BITS];
		if (cmd.commit) begin
			out_bin_q   <= pos_q;
			out_value_q <= OUT_BITS'(mean);
			out_last_q  <= closes;
			out_avail_q <= avail_q | closes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_bin_q    <= LAST_RESET;
			bin_pos_q     <= '0;
			frame_count_q <= '0;
			avail_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) last_bin_q <= cfg_data;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (closes) begin
					bin_pos_q <= '0;
					avail_q   <= 1'b1;
					if (frame_count_q != COUNT_MAX) frame_count_q <= frame_count_q + 1'b1;
				end else begin
					bin_pos_q <= pos_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.copy_mode = (frame_count_q == '0);
	assign sts.div_done  = div_done;
	assign sts.out_free  = out_free;

	assign out_valid         = out_valid_q;
	assign bin_index         = out_bin_q;
	assign noise_value       = out_value_q;
	assign frame_last        = out_last_q;
	assign profile_available = out_avail_q;

endmodule

[rtl/spectral_noise_running_mean.sv]
// Top level: per-bin cumulative mean noise profile, controller plus datapath.
// Flow: a first-frame beat passes IDLE, CALC and DONE; later frames add DIV between
// CALC and DONE, where the restoring divider makes one quotient bit per cycle.
// One bin is in flight at a time, and output stalls hold it in DONE;
// a new beat is taken while a result waits. Reset: arst_n async low clears state machine,
// bin position, frame count, flag, restores last_bin_index to 1024; bin store not cleared.
module spectral_noise_running_mean import snrm_pkg::*; #(
	parameter int MAX_BINS   = DEF_MAX_BINS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config: last bin index
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [BIN_BITS-1:0]   cfg_data,
	// input beats
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] spectrum_value,
	// result beats
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BIN_BITS-1:0]   bin_index,
	output logic [OUT_BITS-1:0]   noise_value,
	output logic                  frame_last,
	output logic                  profile_available
);

	cmd_t cmd;
	sts_t sts;

	// Register writes land in any cycle; the user must issue them only while idle, as the block does not enforce this.
	assign cfg_ready = 1'b1;

	// Controller: IDLE takes a beat, CALC picks copy or divide,
	// DIV waits on the divider, DONE commits once the output slot frees.
	snrm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.sts     (sts),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	// Datapath: store read at capture, mean update m + (v - m) / n,
	// truncating toward zero, write back and result register at commit.
	snrm_dp #(
		.MAX_BINS  (MAX_BINS),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.spectrum_value   (spectrum_value),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.bin_index        (bin_index),
		.noise_value      (noise_value),
		.frame_last       (frame_last),
		.profile_available(profile_available)
	);

	// One bin in flight: an accepted beat closes the input until commit.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a bin is in flight");

	// A new result means the controller has gone back to idle.
	a_commit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result shown but controller not idle");

	// A frame-closing result always reports the profile as available.
	a_last_avail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> profile_available)
		else $error("frame closed without profile flag");

endmodule

[verif/noise_mean_checker.sv]
`timescale 1ns / 100ps
// Watches the running-mean block's channels, predicts each bin result and compares it.
module noise_mean_checker import snrm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [BIN_BITS-1:0]       cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [DEF_VALUE_BITS-1:0] spectrum_value,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [BIN_BITS-1:0]       bin_index,
	input  logic [OUT_BITS-1:0]       noise_value,
	input  logic                      frame_last,
	input  logic                      profile_available,
	output int                        mismatches,
	output int                        pending_results,
	output int                        frames_closed,
	output logic [BIN_BITS-1:0]       store_top
);

	typedef struct packed {
		logic [BIN_BITS-1:0] bin;
		logic [OUT_BITS-1:0] mean;
		logic                closes;
		logic                ready;
	} bin_result_t;

	bin_result_t pending_means[$];

	logic [DEF_VALUE_BITS-1:0] mean_store [DEF_MAX_BINS];
	logic [COUNT_BITS-1:0]     frames_done;
	logic [BIN_BITS-1:0]       next_bin;
	logic [BIN_BITS-1:0]       last_bin;
	logic [BIN_BITS-1:0]       top_written;
	logic                      profile_ready;
	int                        errs;

	// one bin beat: copy in the first frame, cumulative mean after that
	function automatic bin_result_t average_bin(input logic [DEF_VALUE_BITS-1:0] power);
		bin_result_t               res;
		logic [BIN_BITS-1:0]       pos;
		logic [DEF_VALUE_BITS-1:0] mean;
		longint                    divisor;
		longint                    old_mean;
		longint                    delta;
		pos = next_bin;
		if (frames_done == '0) begin
			mean = power;
		end else begin
			divisor = longint'(frames_done) + 1;
			if (divisor > longint'(COUNT_MAX))
				divisor = longint'(COUNT_MAX);
			old_mean = longint'(mean_store[pos]);
			delta    = longint'(power) - old_mean;
			// signed divide truncates toward zero
			mean     = DEF_VALUE_BITS'(old_mean + delta / divisor);
		end
		mean_store[pos] = mean;
		if (pos > top_written)
			top_written = pos;
		res.bin    = pos;
		res.mean   = OUT_BITS'(mean);
		res.closes = (pos >= last_bin);
		if (res.closes) begin
			next_bin = '0;
			if (frames_done != COUNT_MAX)
				frames_done++;
			profile_ready = 1'b1;
		end else begin
			next_bin = pos + 1'b1;
		end
		res.ready = profile_ready;
		return res;
	endfunction

	task automatic check_field(input string field, input logic [OUT_BITS-1:0] want,
		input logic [OUT_BITS-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		if (!arst_n) begin
			frames_done   = '0;
			next_bin      = '0;
			last_bin      = LAST_RESET;
			top_written   = '0;
			profile_ready = 1'b0;
			errs          = 0;
			pending_means.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				last_bin = cfg_data;
			if (in_valid && !in_stall)
				pending_means.push_back(average_bin(spectrum_value));
			if (out_valid && !out_stall) begin
				if (pending_means.size() == 0) begin
					$error("result beat for bin %0d with no bin beat outstanding", bin_index);
					errs++;
				end else begin
					want = pending_means.pop_front();
					check_field("bin_index", OUT_BITS'(want.bin), OUT_BITS'(bin_index));
					check_field("noise_value", want.mean, noise_value);
					check_field("frame_last", OUT_BITS'(want.closes), OUT_BITS'(frame_last));
					check_field("profile_available", OUT_BITS'(want.ready),
						OUT_BITS'(profile_available));
				end
			end
		end
		mismatches      <= errs;
		pending_results <= pending_means.size();
		frames_closed   <= int'(frames_done);
		store_top       <= top_written;
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Testbench top: drives bin beats and last-bin writes into the running-mean block.
module testbench;
	import snrm_pkg::*;

	localparam int RANDOM_BEATS    = 640;
	localparam int HOLD_CYCLES     = 300;   // long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES   = 40;    // settle time before the summary
	localparam int WATCHDOG_CYCLES = 400000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      cfg_valid      = 1'b0;
	logic                      cfg_ready;
	logic [BIN_BITS-1:0]       cfg_data       = '0;
	logic                      in_valid       = 1'b0;
	logic                      in_stall;
	logic [DEF_VALUE_BITS-1:0] spectrum_value = '0;
	logic                      out_valid;
	logic                      out_stall      = 1'b0;
	logic [BIN_BITS-1:0]       bin_index;
	logic [OUT_BITS-1:0]       noise_value;
	logic                      frame_last;
	logic                      profile_available;

	int                  mismatches;
	int                  pending_results;
	int                  frames_closed;
	logic [BIN_BITS-1:0] store_top;

	// stimulus side-channels: set by the sender, read by the receiver process
	logic steady    = 1'b0;     // no idling on either side while high
	int   hold_asks = 0;        // each bump asks the receiver for one long hold-off

	int beats_sent   = 0;
	int random_beats = 0;
	int cfg_writes   = 0;

	always #5 clk = ~clk;

	spectral_noise_running_mean dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.spectrum_value    (spectrum_value),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.bin_index         (bin_index),
		.noise_value       (noise_value),
		.frame_last        (frame_last),
		.profile_available (profile_available)
	);

	noise_mean_checker mean_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.spectrum_value    (spectrum_value),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.bin_index         (bin_index),
		.noise_value       (noise_value),
		.frame_last        (frame_last),
		.profile_available (profile_available),
		.mismatches        (mismatches),
		.pending_results   (pending_results),
		.frames_closed     (frames_closed),
		.store_top         (store_top)
	);

	// Offer one bin beat and hold it until taken. Afterwards the sender may
	// pause with valid low for a random while; inside the steady stretch it never does.
	task automatic send_bin(input logic [DEF_VALUE_BITS-1:0] power);
		in_valid       <= 1'b1;
		spectrum_value <= power;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		if (!steady && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	// Sender pause: stop offering until every bin beat has its result back.
	// pending_results is registered in the checker, so the loop steps the clock before its first test.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	// The register only moves while the block is empty. Each beat yields a
	// result, so an empty result queue means the block is idle.
	task automatic write_last_bin(input logic [BIN_BITS-1:0] last);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= last;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// Once a frame has closed, the block reads back the stored mean of every
	// bin it visits. Bins above the highest one ever written hold garbage, so
	// the last-bin index never goes past store_top from here on.
	function automatic logic [BIN_BITS-1:0] pick_last_bin();
		int unsigned roof;
		roof = store_top;
		unique case ($urandom_range(9))
			0:          return '0;                              // every beat closes a frame
			1:          return BIN_BITS'(roof);                  // widest safe frame
			2:          return 11'd1;                            // two-bin frames
			3, 4, 5, 6: return BIN_BITS'($urandom_range(15));    // short frames, many of them
			default:    return BIN_BITS'($urandom_range(roof));
		endcase
	endfunction

	// Bin power mix: rails, small values (truncation of small differences),
	// single bits, values near 1.0 in Q16.16, and plain random words.
	function automatic logic [DEF_VALUE_BITS-1:0] random_power();
		unique case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return DEF_VALUE_BITS'($urandom_range(255));
			4:       return DEF_VALUE_BITS'(1) << $urandom_range(DEF_VALUE_BITS - 1);
			5:       return 32'h0001_0000 + DEF_VALUE_BITS'($urandom_range(511));
			default: return DEF_VALUE_BITS'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, none in the steady stretch, and
	// one long hold-off on request, counted here while the sender keeps going.
	initial begin : result_sink
		int hold_left;
		int holds_served;
		hold_left    = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_served) begin
				holds_served = hold_asks;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < 11);
			end
		end
	end

	initial begin : watchdog
		for (int cycle = 0; cycle < WATCHDOG_CYCLES; cycle++)
			@(posedge clk);
		$display("watchdog: no verdict after %0d cycles, %0d results outstanding",
			WATCHDOG_CYCLES, pending_results);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int phase_len;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// First frame copies straight into the store. Open it wide (all ones)
		// so it can run past the reset last-bin index if it wanted to.
		write_last_bin(BIN_TOP);
		send_bin(32'h0000_0000);
		send_bin(32'hFFFF_FFFF);
		send_bin(32'h8000_0000);
		send_bin(32'h7FFF_FFFF);
		send_bin(32'h0000_0001);
		send_bin(32'h0001_0000);   // 1.0
		send_bin(32'hAAAA_AAAA);
		send_bin(32'h5555_5555);
		// fill more of the store so later frames can span many bins
		while (beats_sent < 200)
			send_bin(random_power());

		// Lower the index to zero mid-frame: the next beat (bin 200) closes
		// frame one, and from then on every beat is bin 0 closing a frame.
		write_last_bin('0);
		send_bin(32'hFFFF_FFFF);
		send_bin(32'hFFFF_FFFF);   // mean 0 pulled up by the full-scale value
		send_bin(32'h0000_0000);   // negative difference, truncates toward zero
		send_bin(32'h0000_0001);

		write_last_bin(11'd1);
		send_bin(32'h0000_0000);
		send_bin(32'hFFFF_FFFF);

		// --- random ---
		// Phases of random length, with a fresh last-bin index between many
		// of them; a phase boundary need not fall on a frame boundary.
		while (random_beats < RANDOM_BEATS) begin
			if ($urandom_range(2) == 0)
				write_last_bin(pick_last_bin());
			phase_len = $urandom_range(40, 1);
			repeat (phase_len) begin
				if (random_beats == 300)
					hold_asks <= hold_asks + 1;
				steady <= (random_beats >= 420 && random_beats < 570);
				send_bin(random_power());
				random_beats++;
			end
			if ($urandom_range(9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d bin beats (%0d random) through %0d last-bin writes;",
			beats_sent, random_beats, cfg_writes);
		$display("%0d frames averaged, store filled up to bin %0d, %0d mismatches.",
			frames_closed, store_top, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
